// File: rtl/core/ilu5p_pkg.sv
// Shared constants and interface types for the five-point ILU(0) factor block.
// Used by the divider, the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ilu5p_pkg;

  localparam int GRID_WIDTH  = 128;
  localparam int COL_BITS    = $clog2(GRID_WIDTH);
  localparam int ROW_BITS    = 10;
  localparam int ROWCNT_BITS = 11;
  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 24;
  localparam int PROD_BITS   = 2 * VALUE_BITS;
  localparam int TERM_BITS   = PROD_BITS - FRAC_BITS + 1;
  localparam int ACC_BITS    = TERM_BITS + 1;

  // divider: quotient bits produced before the overflow test takes over
  localparam int Q_BITS      = 34;
  localparam int Q_STEPS     = Q_BITS / 2;
  localparam int STEP_BITS   = $clog2(Q_STEPS + 1);

  localparam logic [ROWCNT_BITS-1:0] ROW_COUNT_RESET = ROWCNT_BITS'(128);
  localparam logic [ROWCNT_BITS-1:0] ROW_COUNT_MIN   = ROWCNT_BITS'(2);
  localparam logic [ROWCNT_BITS-1:0] ROW_COUNT_MAX   = ROWCNT_BITS'(1024);

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // APB register map (word index taken from paddr[2])
  localparam int  PADDR_BITS    = 3;
  localparam logic REG_ROW_COUNT = 1'b0;

  typedef struct packed {
    logic                         start;
    logic signed [VALUE_BITS-1:0] num;
    logic signed [VALUE_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic                         fault;
    logic signed [VALUE_BITS-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/ilu5p_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ilu5p_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/ilu5p_div.sv
// Iterative Q8.24 divider, two quotient bits per cycle, saturating.
// Depends on ilu5p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilu5p_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ilu5p_pkg::div_req_t req,
  output ilu5p_pkg::div_rsp_t    rsp
);
  import ilu5p_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN, D_DONE} dstate_t;

  dstate_t                       state;
  logic [VALUE_BITS-1:0]         rem;
  logic [VALUE_BITS-1:0]         dm;
  logic [Q_BITS-1:0]             dvd;
  logic [Q_BITS-1:0]             quo;
  logic [STEP_BITS-1:0]          steps;
  logic                          neg;
  logic                          fault;
  logic signed [VALUE_BITS-1:0]  quot;

  logic [VALUE_BITS-1:0]         nm_in;
  logic [VALUE_BITS-1:0]         dm_in;
  logic                          ovf_in;
  logic [VALUE_BITS:0]           r1;
  logic [VALUE_BITS:0]           r2;
  logic                          ge1;
  logic                          ge2;
  logic [VALUE_BITS-1:0]         r1s;
  logic [VALUE_BITS-1:0]         r2s;

  always_comb begin
    nm_in  = req.num[VALUE_BITS-1] ? VALUE_BITS'(-req.num) : VALUE_BITS'(req.num);
    dm_in  = req.den[VALUE_BITS-1] ? VALUE_BITS'(-req.den) : VALUE_BITS'(req.den);
    // quotient would need more than Q_BITS bits
    ovf_in = {{(Q_BITS-FRAC_BITS){1'b0}}, nm_in} >= {dm_in, {(Q_BITS-FRAC_BITS){1'b0}}};
    r1  = {rem, dvd[Q_BITS-1]};
    ge1 = r1 >= {1'b0, dm};
    r1s = ge1 ? VALUE_BITS'(r1 - {1'b0, dm}) : VALUE_BITS'(r1);
    r2  = {r1s, dvd[Q_BITS-2]};
    ge2 = r2 >= {1'b0, dm};
    r2s = ge2 ? VALUE_BITS'(r2 - {1'b0, dm}) : VALUE_BITS'(r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (req.start) begin
            neg <= req.num[VALUE_BITS-1] ^ req.den[VALUE_BITS-1];
            if (req.den == '0) begin
              fault <= 1'b1;
              quot  <= req.num[VALUE_BITS-1] ? VAL_MIN :
                       ((req.num == '0) ? '0 : VAL_MAX);
              state <= D_DONE;
            end else if (ovf_in) begin
              fault <= 1'b1;
              quot  <= (req.num[VALUE_BITS-1] ^ req.den[VALUE_BITS-1]) ? VAL_MIN : VAL_MAX;
              state <= D_DONE;
            end else begin
              fault <= 1'b0;
              dm    <= dm_in;
              rem   <= VALUE_BITS'(nm_in >> (Q_BITS - FRAC_BITS));
              dvd   <= {nm_in[Q_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
              quo   <= '0;
              steps <= STEP_BITS'(Q_STEPS - 1);
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= r2s;
          dvd <= {dvd[Q_BITS-3:0], 2'b00};
          quo <= {quo[Q_BITS-3:0], ge1, ge2};
          if (steps == '0) begin
            state <= D_FIN;
          end else begin
            steps <= steps - 1'b1;
          end
        end
        D_FIN: begin
          // saturate the magnitude to the signed range
          if (neg) begin
            if (quo > {{(Q_BITS-VALUE_BITS){1'b0}}, VAL_MIN}) begin
              fault <= 1'b1;
              quot  <= VAL_MIN;
            end else begin
              quot  <= VALUE_BITS'(-quo);
            end
          end else begin
            if (quo > {{(Q_BITS-VALUE_BITS){1'b0}}, VAL_MAX}) begin
              fault <= 1'b1;
              quot  <= VAL_MAX;
            end else begin
              quot  <= VALUE_BITS'(quo);
            end
          end
          state <= D_DONE;
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = (state == D_DONE);
  assign rsp.fault = fault;
  assign rsp.quot  = quot;

endmodule

`default_nettype wire

// File: rtl/core/ilu_factor_five_point.sv
// Top level of the five-point ILU(0) factor block: sequencer, shared multiplier,
// APB register and output register. Depends on ilu5p_pkg, ilu5p_ram, ilu5p_div.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_* stream carries one grid cell per request in row order, GRID_WIDTH cells
//   per row, row_count rows per frame, clamped to 2..1024. m_* stream returns one
//   result per cell: pivot, upper_east and upper_north in m_tdata, m_tlast on the
//   final cell of the frame, m_tuser set on a zero pivot or saturated quotient.
//   row_count is written over the APB port (byte address 0) while idle.
//   Each cell runs through one shared 32x32 multiplier (two products) and one
//   shared two-bit-per-cycle divider (up to two quotients), one cell at a time;
//   the next cell can be accepted in the cycle after its result is loaded into
//   the output register. A last-row cell skips the north quotient, and the final
//   cell of a frame skips both quotients. A zero pivot makes the divider skip
//   its iterative steps for each quotient.
//   s_tready is high only while the sequencer waits for a cell; a finished
//   result sits in the output register, and the next cell may be accepted
//   meanwhile. If the receiver stalls, the sequencer holds its next result
//   until the output register empties.
//   Reset clears the previous un, column and row counters and sets row_count
//   to 128; the line buffer is not cleared (the first row never uses it).
module ilu_factor_five_point (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // centre[31:0], east[63:32], north[95:64], west_lower[127:96], south_lower[159:128]
  input  wire logic [5*ilu5p_pkg::VALUE_BITS-1:0]  s_tdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // pivot[31:0], upper_east[63:32], upper_north[95:64]
  output logic [3*ilu5p_pkg::VALUE_BITS-1:0]       m_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic                                     m_tlast,
  // divide_fault[0]
  output logic                                     m_tuser,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ilu5p_pkg::PADDR_BITS-1:0]    paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import ilu5p_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_W, S_MUL_S, S_ACC_W, S_ACC_S, S_SAT,
    S_EAST_GO, S_EAST_WAIT, S_NORTH_GO, S_NORTH_WAIT, S_DONE
  } state_t;

  state_t                       state;
  logic [ROWCNT_BITS-1:0]       row_count;
  logic [COL_BITS-1:0]          col;
  logic [ROW_BITS-1:0]          row;
  logic signed [VALUE_BITS-1:0] prev_un;

  logic signed [VALUE_BITS-1:0] ae, an, ls, lw;
  logic                         use_w, use_s, last_row, last;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [TERM_BITS-1:0]  term;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [VALUE_BITS-1:0] lp, un, ue;
  logic                         fault;

  logic [ROWCNT_BITS-1:0]       rows;
  logic                         in_last_row;
  logic signed [VALUE_BITS-1:0] mul_a, mul_b;
  logic signed [TERM_BITS-1:0]  term_next;
  logic [VALUE_BITS-1:0]        line_rd;
  logic                         out_free;
  logic                         line_we;
  div_req_t                     dreq;
  div_rsp_t                     drsp;

  // APB: single register, writes complete in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROW_COUNT) ? {{(32-ROWCNT_BITS){1'b0}}, row_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_COUNT) begin
      row_count <= pwdata[ROWCNT_BITS-1:0];
    end
  end

  always_comb begin
    if (row_count < ROW_COUNT_MIN) begin
      rows = ROW_COUNT_MIN;
    end else if (row_count > ROW_COUNT_MAX) begin
      rows = ROW_COUNT_MAX;
    end else begin
      rows = row_count;
    end
    in_last_row = {1'b0, row} >= (rows - 1'b1);
  end

  // shared multiplier operands
  always_comb begin
    if (state == S_MUL_W) begin
      mul_a = ls;
      mul_b = prev_un;
    end else begin
      mul_a = lw;
      mul_b = $signed(line_rd);
    end
  end

  // product magnitude shifted right by the fraction bits, sign restored
  always_comb begin
    logic [PROD_BITS-1:0] mag;
    logic [TERM_BITS-1:0] m;
    mag = prod[PROD_BITS-1] ? PROD_BITS'(-prod) : PROD_BITS'(prod);
    m   = {1'b0, mag[PROD_BITS-1:FRAC_BITS]};
    term_next = prod[PROD_BITS-1] ? $signed(TERM_BITS'(-m)) : $signed(m);
  end

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign line_we  = (state == S_DONE) && out_free;

  always_comb begin
    dreq.start = ((state == S_EAST_GO) && !last) || (state == S_NORTH_GO);
    dreq.num   = (state == S_EAST_GO) ? ae : an;
    dreq.den   = lp;
  end

  ilu5p_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (GRID_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (col),
    .wdata (ue),
    .raddr (col),
    .rdata (line_rd)
  );

  ilu5p_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      col      <= '0;
      row      <= '0;
      prev_un  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the sent result unless a new one is loaded below
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ae       <= $signed(s_tdata[2*VALUE_BITS-1:VALUE_BITS]);
            an       <= $signed(s_tdata[3*VALUE_BITS-1:2*VALUE_BITS]);
            ls       <= $signed(s_tdata[4*VALUE_BITS-1:3*VALUE_BITS]);
            lw       <= $signed(s_tdata[5*VALUE_BITS-1:4*VALUE_BITS]);
            acc      <= ACC_BITS'($signed(s_tdata[VALUE_BITS-1:0]));
            use_w    <= !(row == '0 && col == '0);
            use_s    <= (row != '0);
            last_row <= in_last_row;
            last     <= in_last_row && (col == COL_BITS'(GRID_WIDTH - 1));
            un       <= '0;
            ue       <= '0;
            fault    <= 1'b0;
            state    <= S_MUL_W;
          end
        end
        S_MUL_W: begin
          prod  <= mul_a * mul_b;
          state <= S_MUL_S;
        end
        S_MUL_S: begin
          term  <= term_next;
          prod  <= mul_a * mul_b;
          state <= S_ACC_W;
        end
        S_ACC_W: begin
          if (use_w) begin
            acc <= acc - ACC_BITS'(term);
          end
          term  <= term_next;
          state <= S_ACC_S;
        end
        S_ACC_S: begin
          if (use_s) begin
            acc <= acc - ACC_BITS'(term);
          end
          state <= S_SAT;
        end
        S_SAT: begin
          if (acc > ACC_BITS'(VAL_MAX)) begin
            lp <= VAL_MAX;
          end else if (acc < ACC_BITS'(VAL_MIN)) begin
            lp <= VAL_MIN;
          end else begin
            lp <= VALUE_BITS'(acc);
          end
          state <= S_EAST_GO;
        end
        S_EAST_GO: begin
          if (lp == '0) begin
            fault <= 1'b1;
          end
          // skip quotients that are forced to zero
          if (!last) begin
            state <= S_EAST_WAIT;
          end else if (!last_row) begin
            state <= S_NORTH_GO;
          end else begin
            state <= S_DONE;
          end
        end
        S_EAST_WAIT: begin
          if (drsp.done) begin
            un    <= drsp.quot;
            fault <= fault | drsp.fault;
            state <= last_row ? S_DONE : S_NORTH_GO;
          end
        end
        S_NORTH_GO: begin
          state <= S_NORTH_WAIT;
        end
        S_NORTH_WAIT: begin
          if (drsp.done) begin
            ue    <= drsp.quot;
            fault <= fault | drsp.fault;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            m_tdata  <= {ue, un, lp};
            m_tlast  <= last;
            m_tuser  <= fault;
            m_tvalid <= 1'b1;
            prev_un  <= un;
            if (col == COL_BITS'(GRID_WIDTH - 1)) begin
              col <= '0;
              row <= last_row ? '0 : row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
            state <= S_IDLE;
          end else if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sim/ilu_factor_checker.sv
`timescale 1ns / 1ps
// Scoreboard for ilu_factor_five_point: mirrors the row_count register, predicts
// pivot and upper factors for each accepted cell and checks results in order.
// Depends on ilu5p_pkg.

module ilu_factor_checker
  import ilu5p_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [5*VALUE_BITS-1:0] s_tdata,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [3*VALUE_BITS-1:0] m_tdata,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic                    m_tlast,
  input  logic                    m_tuser,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_BITS-1:0]   paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  output int                      error_count,
  output int                      outstanding,
  output int                      results_seen,
  output int                      faults_seen,
  output int                      frames_closed
);

  localparam longint          VMAX     = longint'(VAL_MAX);
  localparam longint          VMIN     = longint'(VAL_MIN);
  localparam longint unsigned QUOT_CAP = 64'd1 << 40;

  typedef struct packed {
    logic [VALUE_BITS-1:0] pivot;
    logic [VALUE_BITS-1:0] upper_east;
    logic [VALUE_BITS-1:0] upper_north;
    logic                  last_cell;
    logic                  divide_fault;
  } factor_t;

  factor_t                 pending_factors[$];
  logic [ROWCNT_BITS-1:0]  row_count = ROW_COUNT_RESET;
  logic [VALUE_BITS-1:0]   prev_upper_east = '0;
  logic [VALUE_BITS-1:0]   upper_north_line [GRID_WIDTH];
  int unsigned             column_index = 0;
  int unsigned             row_index = 0;

  function automatic longint to_long(logic [VALUE_BITS-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint saturate(longint v, inout bit hit);
    if (v > VMAX) begin
      hit = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      hit = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  // exact product, magnitude truncated to Q8.24
  function automatic longint scaled_product(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >> FRAC_BITS;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint scaled_quotient(longint num, longint den, inout bit fault);
    longint unsigned nm;
    longint unsigned dm;
    longint unsigned q;
    if (den == 0) begin
      fault = 1'b1;
      return (num > 0) ? VMAX : ((num < 0) ? VMIN : 0);
    end
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q = (nm << FRAC_BITS) / dm;
    if (q > QUOT_CAP) q = QUOT_CAP;
    return saturate(((num < 0) != (den < 0)) ? -longint'(q) : longint'(q), fault);
  endfunction

  function automatic factor_t factor_cell(logic [5*VALUE_BITS-1:0] d);
    longint      ap, ae, an, ls, lw, lp;
    int unsigned rows, col;
    bit          first_row, last_row, last, fault, pivot_clip;
    factor_t     r;
    ap = to_long(d[0*VALUE_BITS +: VALUE_BITS]);
    ae = to_long(d[1*VALUE_BITS +: VALUE_BITS]);
    an = to_long(d[2*VALUE_BITS +: VALUE_BITS]);
    ls = to_long(d[3*VALUE_BITS +: VALUE_BITS]);
    lw = to_long(d[4*VALUE_BITS +: VALUE_BITS]);
    rows = (row_count < ROW_COUNT_MIN) ? ROW_COUNT_MIN :
           ((row_count > ROW_COUNT_MAX) ? ROW_COUNT_MAX : row_count);
    col = column_index;
    first_row = (row_index == 0);
    // a lowered row_count makes the current row the last one
    last_row = (row_index >= rows - 1);
    last = last_row && (col == GRID_WIDTH - 1);
    fault = 1'b0;
    pivot_clip = 1'b0;
    lp = ap;
    if (!(first_row && col == 0)) lp -= scaled_product(ls, to_long(prev_upper_east));
    if (!first_row) lp -= scaled_product(lw, to_long(upper_north_line[col]));
    // pivot clipping alone leaves divide_fault clear
    lp = saturate(lp, pivot_clip);
    if (lp == 0) fault = 1'b1;
    r.upper_east  = '0;
    r.upper_north = '0;
    if (!last) r.upper_east = VALUE_BITS'(scaled_quotient(ae, lp, fault));
    if (!last_row) r.upper_north = VALUE_BITS'(scaled_quotient(an, lp, fault));
    r.pivot        = VALUE_BITS'(lp);
    r.last_cell    = last;
    r.divide_fault = fault;
    prev_upper_east = r.upper_east;
    upper_north_line[col] = r.upper_north;
    if (col == GRID_WIDTH - 1) begin
      column_index = 0;
      row_index = last_row ? 0 : ((row_index + 1) & 32'h3FF);
    end else begin
      column_index = col + 1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [VALUE_BITS-1:0] want,
                             logic [VALUE_BITS-1:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    factor_t want;
    factor_t got;
    if (rst) begin
      row_count       = ROW_COUNT_RESET;
      prev_upper_east = '0;
      column_index    = 0;
      row_index       = 0;
      pending_factors.delete();
      outstanding     = 0;
      error_count     = 0;
      results_seen    = 0;
      faults_seen     = 0;
      frames_closed   = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_COUNT)
        row_count = pwdata[ROWCNT_BITS-1:0];
      if (s_tvalid && s_tready) begin
        pending_factors.push_back(factor_cell(s_tdata));
        outstanding++;
      end
      if (m_tvalid && m_tready) begin
        got.pivot        = m_tdata[0*VALUE_BITS +: VALUE_BITS];
        got.upper_east   = m_tdata[1*VALUE_BITS +: VALUE_BITS];
        got.upper_north  = m_tdata[2*VALUE_BITS +: VALUE_BITS];
        got.last_cell    = m_tlast;
        got.divide_fault = m_tuser;
        results_seen++;
        if (got.divide_fault) faults_seen++;
        if (got.last_cell) frames_closed++;
        if (pending_factors.size() == 0) begin
          error_count++;
          $error("result with no cell pending: pivot %h", got.pivot);
        end else begin
          want = pending_factors.pop_front();
          outstanding--;
          check_field("pivot", want.pivot, got.pivot);
          check_field("upper_east", want.upper_east, got.upper_east);
          check_field("upper_north", want.upper_north, got.upper_north);
          check_field("last_cell", VALUE_BITS'(want.last_cell),
                      VALUE_BITS'(got.last_cell));
          check_field("divide_fault", VALUE_BITS'(want.divide_fault),
                      VALUE_BITS'(got.divide_fault));
        end
      end
    end
  end

endmodule

// File: sim/ilu_factor_five_point_tb.sv
`timescale 1ns / 1ps
// Testbench top for ilu_factor_five_point: clock, reset, cell stream, APB writes
// and verdict. Depends on ilu5p_pkg, the block and ilu_factor_checker.

module ilu_factor_five_point_tb;
  import ilu5p_pkg::*;

  localparam logic [VALUE_BITS-1:0] Q_ONE = 32'h0100_0000;
  localparam int IDLE_PCT       = 11;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 6;

  typedef struct packed {
    logic [VALUE_BITS-1:0] centre;
    logic [VALUE_BITS-1:0] east;
    logic [VALUE_BITS-1:0] north;
    logic [VALUE_BITS-1:0] west_lower;
    logic [VALUE_BITS-1:0] south_lower;
  } grid_cell_t;

  logic                    clk;
  logic                    rst = 1'b1;
  // centre, east, north, west_lower, south_lower from bit 0 up
  logic [5*VALUE_BITS-1:0] s_tdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // pivot, upper_east, upper_north from bit 0 up
  logic [3*VALUE_BITS-1:0] m_tdata;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic                    m_tlast;
  // divide_fault
  logic                    m_tuser;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_BITS-1:0]   paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  int error_count, outstanding, results_seen, faults_seen, frames_closed;
  bit steady = 1'b0;
  bit stall_armed = 1'b0;
  bit stall_done = 1'b0;
  int idle_cycles = 0;

  ilu_factor_five_point dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ilu_factor_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .error_count(error_count), .outstanding(outstanding),
    .results_seen(results_seen), .faults_seen(faults_seen),
    .frames_closed(frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_armed && !stall_done) begin
        stall_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ilu_factor_five_point_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [VALUE_BITS-1:0] signed_span(int unsigned lim);
    return VALUE_BITS'($urandom_range(0, 2 * lim)) - VALUE_BITS'(lim);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return 32'hFFFF_FFFF;
      4: return 32'd1;
      default: return Q_ONE;
    endcase
  endfunction

  function automatic grid_cell_t random_cell();
    grid_cell_t  c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // diagonally dominant cell, keeps the recurrence in a sane range
      c.centre = $urandom_range(Q_ONE, 8 * Q_ONE);
      if ($urandom_range(0, 3) == 0) c.centre = -c.centre;
      c.east        = signed_span(Q_ONE);
      c.north       = signed_span(Q_ONE);
      c.west_lower  = signed_span(Q_ONE);
      c.south_lower = signed_span(Q_ONE);
    end else if (pick < 75) begin
      c = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (pick < 85) begin
      // tiny pivot: drive the quotients into saturation
      c.centre      = signed_span(32'h0001_0000);
      c.east        = $urandom;
      c.north       = $urandom;
      c.west_lower  = signed_span(256);
      c.south_lower = signed_span(256);
    end else if (pick < 93) begin
      // zero pivot, with zero and nonzero numerators
      c.centre      = '0;
      c.west_lower  = '0;
      c.south_lower = '0;
      c.east        = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
      c.north       = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
    end else begin
      c = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
    end
    return c;
  endfunction

  task automatic send_cell(grid_cell_t c);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {c.south_lower, c.west_lower, c.north, c.east, c.centre};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_count(logic [ROWCNT_BITS-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_ROW_COUNT, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    static int unsigned phase_rows[PHASES]  = '{0, 1024, 2047, 3, 2, 1};
    static int unsigned phase_cells[PHASES] = '{300, 200, 150, 400, 150, 150};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first cell ignores both corrections, first row ignores the south term
    send_cell('{4 * Q_ONE, -Q_ONE, -Q_ONE, VAL_MAX, VAL_MAX});
    send_cell('{4 * Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, VAL_MIN});
    // zero pivot with zero, positive and negative numerators
    send_cell('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cell('{32'd0, Q_ONE, -Q_ONE, 32'd0, 32'd0});
    // quotient overflow in both directions
    send_cell('{32'd1, VAL_MAX, VAL_MIN, 32'd0, 32'd0});
    send_cell('{VAL_MIN, VAL_MIN, VAL_MAX, 32'd0, 32'd0});
    send_cell('{VAL_MAX, VAL_MAX, VAL_MIN, 32'd0, 32'd0});
    send_cell('{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0});
    // pivot clips high, then low
    send_cell('{VAL_MAX, VAL_MAX, 32'd0, VAL_MAX, 32'd0});
    send_cell('{VAL_MIN, 32'd0, 32'd0, VAL_MAX, 32'd0});
    send_cell('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    send_cell('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    send_cell('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_cell('{2 * Q_ONE, Q_ONE / 2, -(Q_ONE / 2), Q_ONE / 4, Q_ONE / 4});
    repeat (100) send_cell(random_cell());

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      write_row_count(ROWCNT_BITS'(phase_rows[p]));
      steady <= (p == 1);
      if (p == 3) stall_armed <= 1'b1;
      repeat (phase_cells[p]) send_cell(random_cell());
    end
    drain_and_settle();

    $display("ilu_factor_five_point_tb: %0d cells checked, row_count 128, 0, 1024, 2047, 3, 2, 1",
             results_seen);
    $display("ilu_factor_five_point_tb: %0d results with divide_fault, %0d frames closed",
             faults_seen, frames_closed);
    if (error_count == 0) begin
      $display("ilu_factor_five_point_tb: done, clean");
    end else begin
      $display("ilu_factor_five_point_tb: done, errors");
    end
    $finish;
  end

endmodule
